/* hw/rtl/spq_pkg.sv */
// Shared types and constants for the stable priority queue.
`default_nettype none

package spq_pkg;

	localparam int VALUE_W = 32;
	localparam int PRIO_W  = 5;
	localparam int POS_W   = 4;
	localparam int MODE_W  = 2;
	localparam int STAT_W  = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_ENQ   = 2'd0,
		MODE_DEQ   = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_LIST  = 2'd3
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_LIST = 1'b1
	} state_t;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic remove;
		logic rotate;
	} cell_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/spq_cell.sv */
// One storage cell of the sorted chain: holds a value and its priority.
`default_nettype none

module spq_cell
	import spq_pkg::*;
(
	input  wire logic               clk,
	input  wire cell_cmd_t          cmd,
	input  wire logic               occupied,
	input  wire logic               is_tail,
	input  wire logic               left_after,
	input  wire logic [VALUE_W-1:0] left_value,
	input  wire logic [PRIO_W-1:0]  left_prio,
	input  wire logic [VALUE_W-1:0] right_value,
	input  wire logic [PRIO_W-1:0]  right_prio,
	input  wire logic [VALUE_W-1:0] head_value,
	input  wire logic [PRIO_W-1:0]  head_prio,
	input  wire logic [VALUE_W-1:0] new_value,
	input  wire logic [PRIO_W-1:0]  new_priority,
	output logic                    after,
	output logic [VALUE_W-1:0]      value,
	output logic [PRIO_W-1:0]       prio
);

	logic [VALUE_W-1:0] value_q;
	logic [PRIO_W-1:0]  prio_q;

	// New item goes behind this entry when ours ranks no later.
	assign after = occupied && (prio_q <= new_priority);
	assign value = value_q;
	assign prio  = prio_q;

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (!after) begin
				if (left_after) begin
					value_q <= new_value;
					prio_q  <= new_priority;
				end else begin
					value_q <= left_value;
					prio_q  <= left_prio;
				end
			end
		end else if (cmd.remove) begin
			value_q <= right_value;
			prio_q  <= right_prio;
		end else if (cmd.rotate) begin
			// Wrap the front entry around to the tail.
			if (is_tail) begin
				value_q <= head_value;
				prio_q  <= head_prio;
			end else begin
				value_q <= right_value;
				prio_q  <= right_prio;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/stable_priority_queue.sv */
// Top level of the stable priority queue: cell chain plus control.
//
// Usage: one input channel (in_valid/in_stall with mode, new_value,
// new_priority) and one result channel (out_valid/out_stall with
// item_value, position, status, last). An item is taken at a clock edge
// where valid is high and stall is low.
// Entries live in a row of DEPTH cells kept sorted by priority number,
// ties in arrival order. Enqueue and dequeue move every cell at once, so
// enqueue, dequeue and clear each give their single result in the cycle
// after acceptance; a new item can follow right away unless out_stall
// holds the result. List rotates the chain once per stored entry and
// reads the front cell each time, one result per entry (a single result
// when empty); the chain is back in its original order when it ends.
// Results sit in one output register; while a result is pending and
// out_stall is high, the result holds, the chain does not advance and
// further items are stalled. Reset empties the queue (count cleared) and
// drops any pending result; cell contents are not cleared.
`default_nettype none

module stable_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [MODE_W-1:0]  mode,
	input  wire logic [VALUE_W-1:0] new_value,
	input  wire logic [PRIO_W-1:0]  new_priority,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [VALUE_W-1:0]      item_value,
	output logic [POS_W-1:0]        position,
	output logic [STAT_W-1:0]       status,
	output logic                    last
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic               out_valid_q, out_valid_d;
	logic [VALUE_W-1:0] item_value_q, item_value_d;
	logic [POS_W-1:0]   position_q, position_d;
	status_t            status_q, status_d;
	logic               last_q, last_d;
	logic               load_out;

	cell_cmd_t          cmd;
	logic               out_free;
	logic               in_fire;
	logic [CNT_W-1:0]   tail_idx;
	logic               idx_is_tail;

	logic [DEPTH-1:0]   cell_after;
	logic [VALUE_W-1:0] cell_value [DEPTH];
	logic [PRIO_W-1:0]  cell_prio  [DEPTH];

	assign out_free    = !out_valid_q || !out_stall;
	assign in_stall    = (state_q != S_IDLE) || !out_free;
	assign in_fire     = in_valid && !in_stall;
	assign tail_idx    = count_q - CNT_W'(1);
	assign idx_is_tail = (CNT_W'(idx_q) == tail_idx);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic               l_after;
		logic [VALUE_W-1:0] l_value, r_value;
		logic [PRIO_W-1:0]  l_prio, r_prio;

		if (i == 0) begin : g_first
			assign l_after = 1'b1;
			assign l_value = cell_value[0];
			assign l_prio  = cell_prio[0];
		end else begin : g_mid
			assign l_after = cell_after[i-1];
			assign l_value = cell_value[i-1];
			assign l_prio  = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_value = cell_value[i];
			assign r_prio  = cell_prio[i];
		end else begin : g_inner
			assign r_value = cell_value[i+1];
			assign r_prio  = cell_prio[i+1];
		end

		spq_cell u_cell (
			.clk          (clk),
			.cmd          (cmd),
			.occupied     (CNT_W'(i) < count_q),
			.is_tail      (CNT_W'(i) == tail_idx),
			.left_after   (l_after),
			.left_value   (l_value),
			.left_prio    (l_prio),
			.right_value  (r_value),
			.right_prio   (r_prio),
			.head_value   (cell_value[0]),
			.head_prio    (cell_prio[0]),
			.new_value    (new_value),
			.new_priority (new_priority),
			.after        (cell_after[i]),
			.value        (cell_value[i]),
			.prio         (cell_prio[i])
		);
	end

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		idx_d        = idx_q;
		out_valid_d  = out_valid_q && out_stall;
		item_value_d = item_value_q;
		position_d   = position_q;
		status_d     = status_q;
		last_d       = last_q;
		load_out     = 1'b0;
		cmd          = '0;

		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					load_out     = 1'b1;
					item_value_d = '0;
					position_d   = '0;
					status_d     = ST_OK;
					last_d       = 1'b1;
					case (mode_t'(mode))
						MODE_ENQ: begin
							if (count_q == CNT_W'(DEPTH)) begin
								status_d = ST_FULL;
							end else begin
								cmd.insert = 1'b1;
								count_d    = count_q + CNT_W'(1);
							end
						end
						MODE_DEQ: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								item_value_d = cell_value[0];
								cmd.remove   = 1'b1;
								count_d      = count_q - CNT_W'(1);
							end
						end
						MODE_CLEAR: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end
							count_d = '0;
						end
						MODE_LIST: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								// No result yet: emission starts next cycle.
								load_out = 1'b0;
								idx_d    = '0;
								state_d  = S_LIST;
							end
						end
						default: begin
							status_d = ST_OK;
						end
					endcase
				end
			end
			S_LIST: begin
				if (out_free) begin
					load_out     = 1'b1;
					item_value_d = cell_value[0];
					position_d   = POS_W'(idx_q);
					status_d     = ST_OK;
					last_d       = idx_is_tail;
					cmd.rotate   = 1'b1;
					idx_d        = idx_q + IDX_W'(1);
					if (idx_is_tail) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (load_out) begin
			out_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			idx_q       <= idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			item_value_q <= item_value_d;
			position_q   <= position_d;
			status_q     <= status_d;
			last_q       <= last_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign item_value = item_value_q;
	assign position   = position_q;
	assign status     = status_q;
	assign last       = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_list_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LIST) |-> (count_q != '0) && (CNT_W'(idx_q) < count_q))
		else $error("list index outside stored entries");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.insert, cmd.remove, cmd.rotate}))
		else $error("more than one chain command at once");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && mode_t'(mode) == MODE_DEQ && count_q != '0)
		|=> count_q == $past(count_q) - CNT_W'(1))
		else $error("dequeue did not remove one entry");

	a_list_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LIST) |=> $stable(count_q))
		else $error("entry count changed during list");

endmodule

`default_nettype wire

/* sim/tb_stable_priority_queue.sv */
// Self-checking testbench for stable_priority_queue: random and directed items against a predictor.
module tb_stable_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int DEPTH       = 16;
	localparam int ITEM_COUNT  = 410;
	localparam int MAX_REPORTS = 200;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]  prio;
	} entry_t;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   pos;
		status_t            st;
		logic               last;
	} answer_t;

	class queue_scoreboard;
		entry_t  held[$];
		answer_t awaited[$];
		int      mismatches;

		task flag_mismatch(string msg);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		function void await_answer(logic [VALUE_W-1:0] value, int pos, status_t st,
				logic last);
			answer_t a;
			a.value = value;
			a.pos   = pos[POS_W-1:0];
			a.st    = st;
			a.last  = last;
			awaited.push_back(a);
		endfunction

		// Work out the results of one accepted item and update the held entries.
		function void apply_command(mode_t op, logic [VALUE_W-1:0] val,
				logic [PRIO_W-1:0] pri);
			entry_t e;
			int     at;
			case (op)
				MODE_ENQ: begin
					if (held.size() >= DEPTH) begin
						await_answer('0, 0, ST_FULL, 1'b1);
					end else begin
						// go behind every entry of equal or smaller number
						at = 0;
						while (at < held.size() && held[at].prio <= pri)
							at++;
						e.value = val;
						e.prio  = pri;
						held.insert(at, e);
						await_answer('0, 0, ST_OK, 1'b1);
					end
				end
				MODE_DEQ: begin
					if (held.size() == 0) begin
						await_answer('0, 0, ST_EMPTY, 1'b1);
					end else begin
						e = held.pop_front();
						await_answer(e.value, 0, ST_OK, 1'b1);
					end
				end
				MODE_CLEAR: begin
					if (held.size() == 0)
						await_answer('0, 0, ST_EMPTY, 1'b1);
					else
						await_answer('0, 0, ST_OK, 1'b1);
					held.delete();
				end
				default: begin
					if (held.size() == 0) begin
						await_answer('0, 0, ST_EMPTY, 1'b1);
					end else begin
						for (int i = 0; i < held.size(); i++)
							await_answer(held[i].value, i, ST_OK, i == held.size() - 1);
					end
				end
			endcase
		endfunction

		task check_result(logic [VALUE_W-1:0] value, logic [POS_W-1:0] pos,
				logic [STAT_W-1:0] st, logic last);
			answer_t a;
			if (awaited.size() == 0) begin
				flag_mismatch($sformatf("unexpected result value=%h status=%0d", value, st));
				return;
			end
			a = awaited.pop_front();
			if (value !== a.value)
				flag_mismatch($sformatf("item_value %h, expected %h", value, a.value));
			if (pos !== a.pos)
				flag_mismatch($sformatf("position %0d, expected %0d", pos, a.pos));
			if (st !== a.st)
				flag_mismatch($sformatf("status %0d, expected %0d", st, a.st));
			if (last !== a.last)
				flag_mismatch($sformatf("last %b, expected %b", last, a.last));
		endtask
	endclass

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic [MODE_W-1:0]   mode         = MODE_ENQ;
	logic [VALUE_W-1:0]  new_value    = '0;
	logic [PRIO_W-1:0]   new_priority = '0;
	logic                out_stall    = 1'b0;
	logic                gaps_on      = 1'b1;
	logic                in_stall;
	logic                out_valid;
	logic [VALUE_W-1:0]  item_value;
	logic [POS_W-1:0]    position;
	logic [STAT_W-1:0]   status;
	logic                last;

	queue_scoreboard sb = new();

	stable_priority_queue #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.new_value    (new_value),
		.new_priority (new_priority),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.item_value   (item_value),
		.position     (position),
		.status       (status),
		.last         (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= gaps_on && ($urandom_range(0, 99) < 12);
	end

	// Sample both channels at the edge, before any update of this step lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(item_value, position, status, last);
			if (in_valid && !in_stall)
				sb.apply_command(mode_t'(mode), new_value, new_priority);
		end
	end

	task automatic send_item(mode_t op, logic [VALUE_W-1:0] val, logic [PRIO_W-1:0] pri);
		while (gaps_on && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= op;
		new_value    <= val;
		new_priority <= pri;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	initial begin
		mode_t              op;
		logic [VALUE_W-1:0] val;
		logic [PRIO_W-1:0]  pri;
		int                 roll;
		int                 enq_cut;
		int                 deq_cut;
		int                 list_cut;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// empty queue on list, dequeue and clear
		send_item(MODE_LIST, 32'hFFFF_FFFF, 5'd31);
		send_item(MODE_DEQ, 32'h1234_5678, 5'd7);
		send_item(MODE_CLEAR, 32'hFFFF_FFFF, 5'd31);
		// value and priority extremes, ties in arrival order
		send_item(MODE_ENQ, 32'h8000_0000, 5'd31);
		send_item(MODE_ENQ, 32'h7FFF_FFFF, 5'd0);
		send_item(MODE_ENQ, 32'h0000_0000, 5'd16);
		send_item(MODE_ENQ, 32'hFFFF_FFFF, 5'd16);
		send_item(MODE_ENQ, 32'h0000_0005, 5'd16);
		send_item(MODE_ENQ, 32'h0000_0001, 5'd31);
		send_item(MODE_ENQ, 32'hAAAA_AAAA, 5'd0);
		send_item(MODE_LIST, 32'h0, 5'd0);
		send_item(MODE_DEQ, 32'h0, 5'd0);
		send_item(MODE_DEQ, 32'h0, 5'd0);
		send_item(MODE_LIST, 32'h5555_5555, 5'd21);
		send_item(MODE_CLEAR, 32'h0, 5'd0);
		send_item(MODE_LIST, 32'h0, 5'd0);
		send_item(MODE_DEQ, 32'h0, 5'd0);

		// phases that fill, drain and mix, with a stretch of no gaps
		for (int n = 0; n < ITEM_COUNT; n++) begin
			if (n == 150)
				gaps_on <= 1'b0;
			if (n == 230)
				gaps_on <= 1'b1;
			case ((n / 40) % 3)
				0: begin
					enq_cut = 80; deq_cut = 88; list_cut = 98;
				end
				1: begin
					enq_cut = 20; deq_cut = 85; list_cut = 97;
				end
				default: begin
					enq_cut = 45; deq_cut = 80; list_cut = 95;
				end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < enq_cut)
				op = MODE_ENQ;
			else if (roll < deq_cut)
				op = MODE_DEQ;
			else if (roll < list_cut)
				op = MODE_LIST;
			else
				op = MODE_CLEAR;
			roll = $urandom_range(0, 19);
			if (roll == 0)
				val = 32'h8000_0000;
			else if (roll == 1)
				val = 32'h7FFF_FFFF;
			else
				val = $urandom;
			// narrow priorities half the time to force ties
			if ($urandom_range(0, 1) != 0)
				pri = $urandom_range(0, 3);
			else
				pri = $urandom_range(0, 31);
			send_item(op, val, pri);
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("stable_priority_queue regression: pass");
		else
			$display("stable_priority_queue regression: fail");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("stable_priority_queue regression: fail");
		$finish;
	end

endmodule
